### hw/rtl/vlr_pkg.sv
// ----------------------------------------------------------------------------
// vlr_pkg: shared types and codes for the voice lifetime reaper
// Transaction payloads, slot entry layout, action, mode and cause codes.
// ----------------------------------------------------------------------------
package vlr_pkg;

   localparam int SAMPLE_BITS = 24;
   localparam int SLOT_W      = 6;
   localparam int GEN_W       = 16;
   localparam int AGE_W       = 32;
   localparam int SILENT_W    = 16;
   localparam int THRESH_W    = 24;

   typedef enum logic [1:0] {
      ACT_ACTIVATE  = 2'd0,
      ACT_KILL      = 2'd1,
      ACT_SAMPLE    = 2'd2,
      ACT_BLOCK_END = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_PERMANENT = 2'd0,
      MODE_TIMED     = 2'd1,
      MODE_FINISHED  = 2'd2,
      MODE_SILENT    = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CAUSE_FINISHED  = 2'd0,
      CAUSE_KILLED    = 2'd1,
      CAUSE_TIMED_OUT = 2'd2,
      CAUSE_SILENT    = 2'd3
   } cause_type;

   typedef struct packed {
      action_type                     action;
      logic [SLOT_W-1:0]              slot;
      logic [GEN_W-1:0]               generation;
      mode_type                       lifetime_mode;
      logic [AGE_W-1:0]               ttl_limit;
      logic [THRESH_W-1:0]            quiet_threshold;
      logic [SILENT_W-1:0]            quiet_limit;
      logic signed [SAMPLE_BITS-1:0]  sample_value;
      logic                           done_flag;
   } req_type;

   typedef struct packed {
      logic              applied;
      logic              reaped;
      logic [SLOT_W-1:0] reaped_slot;
      logic [GEN_W-1:0]  reaped_generation;
      cause_type         end_cause;
   } rsp_type;

   // One memory word per slot.
   typedef struct packed {
      logic [GEN_W-1:0]       live_generation;
      logic [AGE_W-1:0]       age_count;
      logic [SILENT_W-1:0]    silent_count;
      mode_type               stored_mode;
      logic [AGE_W-1:0]       stored_ttl;
      logic [THRESH_W-1:0]    stored_threshold;
      logic [SILENT_W-1:0]    stored_quiet_limit;
      logic [SAMPLE_BITS-1:0] running_peak;
   } entry_type;

endpackage

### hw/rtl/voice_lifetime_reaper.sv
// ----------------------------------------------------------------------------
// voice_lifetime_reaper: per-slot voice lifetime tracker
// Activate, kill, sample-peak and block-end ageing over a slot memory,
// one result transaction per request transaction.
// ----------------------------------------------------------------------------
//
//  channel   ports                     handshake
//  --------  ------------------------  ------------------------------------
//  request   start, busy, req_data     taken when start=1 and busy=0
//  result    rsp_valid, rsp_data       one-cycle strobe, always taken
//
// Flow: accepting a request issues the slot memory read; the compute
//   stage then does modify/write-back and registers the result. busy
//   covers that compute stage; the registered memory read plus write-back
//   interlock keeps a new request from being taken during compute.
// Result shows the cycle after compute, so a new request overlaps it.
// Reset: synchronous; afterwards a clearing pass writes every slot free,
//   with busy held high.
// Stalls: the result side cannot stall; only busy holds requests off.
//
module voice_lifetime_reaper #(
   parameter int SLOTS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  vlr_pkg::req_type req_data,
   output logic             rsp_valid,
   output vlr_pkg::rsp_type rsp_data
);
   import vlr_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // slot memory, single write / single read port, registered read
   entry_type mem [SLOTS];

   entry_type          rd_data_ff;
   logic [IDX_W-1:0]   rd_idx;

   logic               wr_en;
   logic [IDX_W-1:0]   wr_idx;
   entry_type          wr_data;

   // clearing pass
   logic               sweep_active_ff, sweep_active_in;
   logic [IDX_W-1:0]   sweep_idx_ff, sweep_idx_in;

   // compute stage
   logic               stage_valid_ff, stage_valid_in;
   req_type            req_ff;

   rsp_type            rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff;

   entry_type          new_ent;
   logic               commit;
   logic               accept;

   // per-item working values
   entry_type              ent;
   logic                   active;
   logic                   in_range;
   logic [SAMPLE_BITS-1:0] mag;
   logic [AGE_W-1:0]       age_next;
   logic [SILENT_W-1:0]    silent_next;

   assign busy   = reset | sweep_active_ff | stage_valid_ff;
   assign accept = start & ~busy;
   assign rd_idx = IDX_W'(req_data.slot);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_idx];
      if (wr_en) begin
         mem[wr_idx] <= wr_data;
      end
   end

   // sweep and stage control
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_idx_in    = sweep_idx_ff;
      if (sweep_active_ff) begin
         sweep_idx_in = sweep_idx_ff + 1'b1;
         if (sweep_idx_ff == IDX_W'(SLOTS - 1)) begin
            sweep_active_in = 1'b0;
         end
      end
      stage_valid_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b1;
         sweep_idx_ff    <= '0;
         stage_valid_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         sweep_idx_ff    <= sweep_idx_in;
         stage_valid_ff  <= stage_valid_in;
         rsp_valid_ff    <= stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // read-modify of the addressed slot
   always_comb begin
      ent      = rd_data_ff;
      active   = (ent.live_generation != '0);
      in_range = (32'(req_ff.slot) < SLOTS);
      mag      = req_ff.sample_value[SAMPLE_BITS-1]
                 ? (~req_ff.sample_value + 1'b1) : req_ff.sample_value;
      age_next = (ent.age_count == '1) ? ent.age_count : ent.age_count + 1'b1;
      if (32'(ent.running_peak) < 32'(ent.stored_threshold)) begin
         silent_next = (ent.silent_count == '1) ? ent.silent_count
                       : ent.silent_count + 1'b1;
      end else begin
         silent_next = '0;
      end

      new_ent     = ent;
      commit      = 1'b0;
      rsp_data_in = '0;

      if (stage_valid_ff && in_range) begin
         case (req_ff.action)
            ACT_ACTIVATE: begin
               if (!active && req_ff.generation != '0) begin
                  new_ent.live_generation    = req_ff.generation;
                  new_ent.stored_mode        = req_ff.lifetime_mode;
                  new_ent.stored_ttl         = req_ff.ttl_limit;
                  new_ent.stored_threshold   = req_ff.quiet_threshold;
                  new_ent.stored_quiet_limit = req_ff.quiet_limit;
                  new_ent.age_count          = '0;
                  new_ent.silent_count       = '0;
                  new_ent.running_peak       = '0;
                  commit                     = 1'b1;
                  rsp_data_in.applied        = 1'b1;
               end
            end
            ACT_KILL: begin
               if (active && ent.live_generation == req_ff.generation) begin
                  commit                = 1'b1;
                  rsp_data_in.applied   = 1'b1;
                  rsp_data_in.reaped    = 1'b1;
                  rsp_data_in.end_cause = CAUSE_KILLED;
               end
            end
            ACT_SAMPLE: begin
               if (active) begin
                  if (mag > ent.running_peak) begin
                     new_ent.running_peak = mag;
                  end
                  commit              = 1'b1;
                  rsp_data_in.applied = 1'b1;
               end
            end
            ACT_BLOCK_END: begin
               if (active) begin
                  commit               = 1'b1;
                  rsp_data_in.applied  = 1'b1;
                  new_ent.running_peak = '0;
                  if (req_ff.done_flag) begin
                     rsp_data_in.reaped    = 1'b1;
                     rsp_data_in.end_cause = CAUSE_FINISHED;
                  end else begin
                     new_ent.age_count = age_next;
                     if (ent.stored_mode == MODE_TIMED) begin
                        if (age_next >= ent.stored_ttl) begin
                           rsp_data_in.reaped    = 1'b1;
                           rsp_data_in.end_cause = CAUSE_TIMED_OUT;
                        end
                     end else if (ent.stored_mode == MODE_SILENT) begin
                        new_ent.silent_count = silent_next;
                        if (silent_next >= ent.stored_quiet_limit) begin
                           rsp_data_in.reaped    = 1'b1;
                           rsp_data_in.end_cause = CAUSE_SILENT;
                        end
                     end
                  end
               end
            end
            default: begin
               commit = 1'b0;
            end
         endcase
      end

      // release frees the slot and drops its peak
      if (rsp_data_in.reaped) begin
         rsp_data_in.reaped_slot       = req_ff.slot;
         rsp_data_in.reaped_generation = ent.live_generation;
         new_ent.live_generation       = '0;
         new_ent.running_peak          = '0;
      end
   end

   // write port: clearing pass has priority, never overlaps a transaction
   always_comb begin
      if (sweep_active_ff) begin
         wr_en   = 1'b1;
         wr_idx  = sweep_idx_ff;
         wr_data = '0;
      end else begin
         wr_en   = commit;
         wr_idx  = IDX_W'(req_ff.slot);
         wr_data = new_ent;
      end
   end

`ifndef SYNTHESIS
   a_rsp_after_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(stage_valid_ff))
      else $error("result strobe without a computed transaction");

   a_accept_to_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> stage_valid_ff)
      else $error("accepted transaction did not enter compute stage");

   a_single_stage: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |=> !stage_valid_ff)
      else $error("back-to-back compute without interlock");

   a_no_sweep_overlap: assert property (@(posedge clock) disable iff (reset)
      !(sweep_active_ff && stage_valid_ff))
      else $error("transaction during clearing pass");

   a_reap_applied: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.reaped) |-> rsp_data_ff.applied)
      else $error("release reported without applied");
`endif

endmodule
